// ----- src/ses_pkg.sv -----
// ses_pkg: shared constants, types and codes for the smallest enclosing sphere lookup
// no dependencies; every other file refers to it by scoped names
`default_nettype none

package ses_pkg;

   // table geometry
   localparam int MAX_SPHERES = 256;
   localparam int SLOT_W      = $clog2(MAX_SPHERES);
   localparam int TAB_DEPTH   = 2 * MAX_SPHERES;
   localparam int TAB_AW      = $clog2(TAB_DEPTH);
   localparam int CNT_W       = $clog2(MAX_SPHERES + 1);

   // field widths
   localparam int COUNT_W     = 9;
   localparam int ENTRY_W     = 8;
   localparam int INDEX_W     = 8;
   localparam int COORD_W     = 16;
   localparam int RAD_W       = 16;
   localparam int SQ_W        = 2 * COORD_W;
   localparam int R2_W        = 2 * RAD_W;
   localparam int SUM_W       = SQ_W + 2;
   localparam int NUM_AXES    = 3;
   localparam int CSR_IDX_W   = 1;

   // request modes
   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_A = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_B = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic [COORD_W-1:0] cx;
      logic [COORD_W-1:0] cy;
      logic [COORD_W-1:0] cz;
      logic [RAD_W-1:0]   rad;
   } sphere_type;

   // one table entry travelling down the cell row
   typedef struct packed {
      logic                             valid;
      logic                             last;
      logic [SLOT_W-1:0]                index;
      logic [RAD_W-1:0]                 rad;
      logic [NUM_AXES-1:0][COORD_W-1:0] coord;
      logic [SUM_W-1:0]                 sum;
   } token_type;

   typedef struct packed {
      logic              done;
      logic              found;
      logic [SLOT_W-1:0] index;
   } pick_status_type;

endpackage

`default_nettype wire

// ----- src/ses_store.sv -----
// ses_store: sphere table for both chains, one write and one registered read a cycle
// depends on ses_pkg
`default_nettype none

module ses_store (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [ses_pkg::TAB_AW-1:0]  wr_addr,
   input  wire ses_pkg::sphere_type         wr_data,
   input  wire logic                        rd_en,
   input  wire logic [ses_pkg::TAB_AW-1:0]  rd_addr,
   output ses_pkg::sphere_type              rd_data
);

   ses_pkg::sphere_type mem [ses_pkg::TAB_DEPTH];
   ses_pkg::sphere_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/ses_cell.sv -----
// ses_cell: one axis cell, holds one query coordinate and adds its squared distance
// depends on ses_pkg; three stages: abs difference, square, accumulate
`default_nettype none

module ses_cell (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             load_point,
   input  wire logic signed [ses_pkg::COORD_W-1:0] point_coord,
   input  wire ses_pkg::token_type               tok_in,
   output ses_pkg::token_type                    tok_out
);

   logic signed [ses_pkg::COORD_W-1:0] point_ff;
   logic signed [ses_pkg::COORD_W:0]   diff;
   logic [ses_pkg::COORD_W-1:0]        absdiff_in;
   logic [ses_pkg::COORD_W-1:0]        absdiff_ff;
   logic [ses_pkg::SQ_W-1:0]           sq_ff;
   ses_pkg::token_type                 tok_a_in;
   ses_pkg::token_type                 tok_a_ff;
   ses_pkg::token_type                 tok_b_ff;
   ses_pkg::token_type                 tok_c_in;
   ses_pkg::token_type                 tok_c_ff;

   always_ff @(posedge clock) begin
      if (load_point) begin
         point_ff <= point_coord;
      end
   end

   // this cell uses coord[0]; the next cell finds its axis in coord[0] after rotation
   always_comb begin
      diff = {point_ff[ses_pkg::COORD_W-1], point_ff}
           - {tok_in.coord[0][ses_pkg::COORD_W-1], tok_in.coord[0]};
      absdiff_in = diff[ses_pkg::COORD_W] ? ses_pkg::COORD_W'(-diff)
                                          : ses_pkg::COORD_W'(diff);
      tok_a_in = tok_in;
      for (int i = 0; i < ses_pkg::NUM_AXES; i++) begin
         tok_a_in.coord[i] = tok_in.coord[(i + 1) % ses_pkg::NUM_AXES];
      end
   end

   always_comb begin
      tok_c_in     = tok_b_ff;
      tok_c_in.sum = tok_b_ff.sum + ses_pkg::SUM_W'(sq_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_a_ff <= '0;
         tok_b_ff <= '0;
         tok_c_ff <= '0;
      end else begin
         tok_a_ff <= tok_a_in;
         tok_b_ff <= tok_a_ff;
         tok_c_ff <= tok_c_in;
      end
   end

   always_ff @(posedge clock) begin
      absdiff_ff <= absdiff_in;
      sq_ff      <= absdiff_ff * absdiff_ff;
   end

   assign tok_out = tok_c_ff;

endmodule

`default_nettype wire

// ----- src/ses_pick.sv -----
// ses_pick: radius square, enclosure test and running choice of the smallest sphere
// depends on ses_pkg; fed by the last axis cell
`default_nettype none

module ses_pick (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                clear,
   input  wire ses_pkg::token_type  tok_in,
   output ses_pkg::pick_status_type status
);

   logic                         valid_ff;
   logic                         last_ff;
   logic [ses_pkg::SLOT_W-1:0]   index_ff;
   logic [ses_pkg::RAD_W-1:0]    rad_ff;
   logic [ses_pkg::SUM_W-1:0]    d2_ff;
   logic [ses_pkg::R2_W-1:0]     r2_ff;
   logic                         enclosed;
   logic                         take;
   logic                         found_ff;
   logic [ses_pkg::SLOT_W-1:0]   best_index_ff;
   logic [ses_pkg::RAD_W-1:0]    best_rad_ff;
   logic                         done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         valid_ff <= tok_in.valid;
         last_ff  <= tok_in.last;
      end
   end

   always_ff @(posedge clock) begin
      index_ff <= tok_in.index;
      rad_ff   <= tok_in.rad;
      d2_ff    <= tok_in.sum;
      r2_ff    <= tok_in.rad * tok_in.rad;
   end

   // strict compare keeps the lower index on equal radii
   always_comb begin
      enclosed = d2_ff <= ses_pkg::SUM_W'(r2_ff);
      take     = valid_ff && enclosed && (!found_ff || (rad_ff < best_rad_ff));
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         found_ff      <= 1'b0;
         best_index_ff <= '0;
         best_rad_ff   <= '0;
         done_ff       <= 1'b0;
      end else begin
         done_ff <= valid_ff && last_ff;
         if (take) begin
            found_ff      <= 1'b1;
            best_index_ff <= index_ff;
            best_rad_ff   <= rad_ff;
         end
      end
   end

   assign status.done  = done_ff;
   assign status.found = found_ff;
   assign status.index = best_index_ff;

endmodule

`default_nettype wire

// ----- src/smallest_enclosing_sphere_lookup.sv -----
// smallest_enclosing_sphere_lookup: top level, sequencer, count registers and result register
// depends on ses_pkg, ses_store, ses_cell and ses_pick
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    mode, chain, entry_index, pos_x/y/z, sphere_radius
//   rsp      out        rsp_valid/stall    result_chain, found, sphere_index
//   csr      in         csr_write_en       csr_index, csr_wdata (sphere counts)
//
// an accepted load request writes one table entry
// a query over n > 0 spheres scans n entries between acceptance and the result register:
//   the table has one read port, so the scan streams one entry per cycle
//   through the read register, three axis cells of three stages and the pick stages
// a query with no spheres in use skips the scan and goes straight to the result state
// reset clears the counts, the sequencer and the result register; table contents survive
// req_stall is high from a query's acceptance until its result enters the result register;
// a result held by rsp_stall does not block the next request
`default_nettype none

module smallest_enclosing_sphere_lookup (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic                               req_mode,
   input  wire logic                               req_chain,
   input  wire logic [ses_pkg::ENTRY_W-1:0]        req_entry_index,
   input  wire logic signed [ses_pkg::COORD_W-1:0] req_pos_x,
   input  wire logic signed [ses_pkg::COORD_W-1:0] req_pos_y,
   input  wire logic signed [ses_pkg::COORD_W-1:0] req_pos_z,
   input  wire logic [ses_pkg::RAD_W-1:0]          req_sphere_radius,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic                                    rsp_result_chain,
   output logic                                    rsp_found,
   output logic [ses_pkg::INDEX_W-1:0]             rsp_sphere_index,
   input  wire logic                               csr_write_en,
   input  wire logic [ses_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [ses_pkg::COUNT_W-1:0]        csr_wdata
);

   ses_pkg::state_type          state_ff;
   ses_pkg::state_type          state_in;

   logic [ses_pkg::COUNT_W-1:0] count_a_ff;
   logic [ses_pkg::COUNT_W-1:0] count_b_ff;
   logic [ses_pkg::COUNT_W-1:0] count_sel;

   logic                        chain_ff;
   logic [ses_pkg::CNT_W-1:0]   scan_cnt_ff;
   logic [ses_pkg::CNT_W-1:0]   scan_cnt_in;
   logic [ses_pkg::CNT_W-1:0]   scan_end_ff;
   logic [ses_pkg::CNT_W-1:0]   scan_end_in;

   logic                        req_accept;
   logic                        query_accept;
   logic                        load_write;
   logic                        scan_last;
   logic                        rd_en;
   logic [ses_pkg::TAB_AW-1:0]  rd_addr;
   logic [ses_pkg::TAB_AW-1:0]  wr_addr;
   ses_pkg::sphere_type         wr_data;
   ses_pkg::sphere_type         rd_data;

   // token metadata travels beside the registered memory read
   logic                        rd_valid_ff;
   logic                        rd_last_ff;
   logic [ses_pkg::SLOT_W-1:0]  rd_index_ff;

   ses_pkg::token_type          cell_tok [ses_pkg::NUM_AXES+1];
   logic signed [ses_pkg::COORD_W-1:0] point_coord [ses_pkg::NUM_AXES];
   ses_pkg::pick_status_type    pick_status;

   logic                        rsp_load;
   logic                        rsp_valid_ff;
   logic                        rsp_chain_ff;
   logic                        rsp_found_ff;
   logic [ses_pkg::INDEX_W-1:0] rsp_index_ff;

   // request handshake: only an idle sequencer takes requests
   assign req_stall    = (state_ff != ses_pkg::ST_IDLE);
   assign req_accept   = req_valid && !req_stall;
   assign query_accept = req_accept && (req_mode == ses_pkg::MODE_QUERY);

   // loads beyond the table capacity are dropped
   assign load_write = req_accept && (req_mode == ses_pkg::MODE_LOAD)
                     && (32'(req_entry_index) < 32'(ses_pkg::MAX_SPHERES));
   assign wr_addr    = {req_chain, ses_pkg::SLOT_W'(req_entry_index)};
   assign wr_data    = '{cx: req_pos_x, cy: req_pos_y, cz: req_pos_z, rad: req_sphere_radius};

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff <= '0;
         count_b_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            ses_pkg::CSR_COUNT_A: count_a_ff <= csr_wdata;
            ses_pkg::CSR_COUNT_B: count_b_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // count above capacity is saturated for the scan
   always_comb begin
      count_sel = req_chain ? count_b_ff : count_a_ff;
      if (32'(count_sel) > 32'(ses_pkg::MAX_SPHERES)) begin
         scan_end_in = ses_pkg::CNT_W'(ses_pkg::MAX_SPHERES);
      end else begin
         scan_end_in = ses_pkg::CNT_W'(count_sel);
      end
   end

   assign scan_last = (scan_cnt_ff == (scan_end_ff - ses_pkg::CNT_W'(1)));
   assign rd_addr   = {chain_ff, scan_cnt_ff[ses_pkg::SLOT_W-1:0]};

   // sequencer: next state and strobes
   always_comb begin
      state_in    = state_ff;
      scan_cnt_in = scan_cnt_ff;
      rd_en       = 1'b0;
      rsp_load    = 1'b0;
      case (state_ff)
         ses_pkg::ST_IDLE: begin
            if (query_accept) begin
               scan_cnt_in = '0;
               // a sphere count of zero skips the scan and answers with nothing found
               state_in    = (scan_end_in == '0) ? ses_pkg::ST_RESULT : ses_pkg::ST_SCAN;
            end
         end
         ses_pkg::ST_SCAN: begin
            rd_en       = 1'b1;
            scan_cnt_in = scan_cnt_ff + ses_pkg::CNT_W'(1);
            if (scan_last) begin
               state_in = ses_pkg::ST_DRAIN;
            end
         end
         ses_pkg::ST_DRAIN: begin
            if (pick_status.done) begin
               state_in = ses_pkg::ST_RESULT;
            end
         end
         ses_pkg::ST_RESULT: begin
            // wait for the result register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ses_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ses_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ses_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_cnt_ff <= scan_cnt_in;
      if (query_accept) begin
         chain_ff    <= req_chain;
         scan_end_ff <= scan_end_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
         rd_last_ff  <= 1'b0;
      end else begin
         rd_valid_ff <= rd_en;
         rd_last_ff  <= rd_en && scan_last;
      end
   end

   always_ff @(posedge clock) begin
      rd_index_ff <= scan_cnt_ff[ses_pkg::SLOT_W-1:0];
   end

   ses_store u_store (
      .clock   (clock),
      .wr_en   (load_write),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // head of the cell row: fresh entry with an empty distance sum
   always_comb begin
      cell_tok[0].valid    = rd_valid_ff;
      cell_tok[0].last     = rd_last_ff;
      cell_tok[0].index    = rd_index_ff;
      cell_tok[0].rad      = rd_data.rad;
      cell_tok[0].coord[0] = rd_data.cx;
      cell_tok[0].coord[1] = rd_data.cy;
      cell_tok[0].coord[2] = rd_data.cz;
      cell_tok[0].sum      = '0;
   end

   // cell k holds axis k of the query point
   assign point_coord[0] = req_pos_x;
   assign point_coord[1] = req_pos_y;
   assign point_coord[2] = req_pos_z;

   for (genvar k = 0; k < ses_pkg::NUM_AXES; k++) begin : g_cell
      ses_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .load_point  (query_accept),
         .point_coord (point_coord[k]),
         .tok_in      (cell_tok[k]),
         .tok_out     (cell_tok[k+1])
      );
   end

   ses_pick u_pick (
      .clock  (clock),
      .reset  (reset),
      .clear  (query_accept),
      .tok_in (cell_tok[ses_pkg::NUM_AXES]),
      .status (pick_status)
   );

   // result register, parts the scan from the response side
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_chain_ff <= chain_ff;
         rsp_found_ff <= pick_status.found;
         rsp_index_ff <= pick_status.found ? ses_pkg::INDEX_W'(pick_status.index) : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_chain = rsp_chain_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_sphere_index = rsp_index_ff;

`ifndef SYNTH
   // a new result only ever comes out of the result state
   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ses_pkg::ST_RESULT))
      else $error("result raised outside the result state");

   // the end of a scan reaches the pick stage only after all reads were issued
   a_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      pick_status.done |-> (state_ff == ses_pkg::ST_DRAIN))
      else $error("scan finished outside the drain state");

   // the last cell puts out no valid entry whenever the sequencer is idle
   a_row_empty_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ses_pkg::ST_IDLE) |-> !cell_tok[ses_pkg::NUM_AXES].valid)
      else $error("entry still in the cell row while idle");
`endif

endmodule

`default_nettype wire
